>>> sv/sang_pkg.sv
// sang_pkg: constants, types and helper functions for the signed angle core
// used by signed_angle_about_axis_core; no dependencies

package sang_pkg;

  // default configuration of the core
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // internal fixed-point layout
  localparam int NORM_BITS    = 24;
  localparam int SQRT_STEPS   = 31;
  localparam int CORDIC_STEPS = 30;
  localparam int CROSS_MAX_LOG = 30;

  localparam logic [30:0] MIN_LENGTH_SQ_RST = 31'd7;

  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;

  // normalized vector component: magnitude at most 2^24
  typedef logic signed [NORM_BITS:0] norm_t;

  // cordic rotation angle atan(2^-i) in q30
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] v;
    case (i)
      0:       v = 34'sd843314857;
      1:       v = 34'sd497837829;
      2:       v = 34'sd263043837;
      3:       v = 34'sd133525159;
      4:       v = 34'sd67021687;
      5:       v = 34'sd33543516;
      6:       v = 34'sd16775851;
      7:       v = 34'sd8388437;
      8:       v = 34'sd4194283;
      9:       v = 34'sd2097149;
      default: v = 34'sd1 <<< (30 - i);
    endcase
    return v;
  endfunction

  // number of significant bits of an unsigned word
  function automatic logic [6:0] bitlen64(input logic [63:0] m);
    logic [6:0] n;
    n = '0;
    for (int b = 0; b < 64; b++) begin
      if (m[b]) n = 7'(b + 1);
    end
    return n;
  endfunction

endpackage

>>> sv/signed_angle_about_axis_core.sv
// signed_angle_about_axis_core: pipelined signed angle of two 3d vectors about an axis
// depends on sang_pkg for constants, the atan table and the bit-length helper
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+---------------------
//   input   | in_start_*, in_end_*, in_axis_*         | in_valid / in_ready
//   result  | out_angle, out_degenerate               | out_valid / out_ready
//   config  | cfg_wdata (min_length_sq)               | cfg_we, no wait
//
// one item per cycle unless the output stalls; the 31-stage square root
// and the 30-stage cordic give one bit or one rotation per stage.
// rst_n is synchronous and clears all valid bits and the threshold (to 7).
// the whole pipeline advances together; when the output register holds an
// item that is not taken, every stage holds and in_ready is low.

module signed_angle_about_axis_core #(
  parameter int COORD_WIDTH = sang_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sang_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_start_z,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_z,
  input  logic signed [COORD_WIDTH-1:0] in_axis_x,
  input  logic signed [COORD_WIDTH-1:0] in_axis_y,
  input  logic signed [COORD_WIDTH-1:0] in_axis_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [FRAC_BITS+2:0]   out_angle,
  output logic                          out_degenerate,
  input  logic                          cfg_we,
  input  logic [30:0]                   cfg_wdata
);

  localparam int W   = COORD_WIDTH;
  localparam int AW  = FRAC_BITS + 3;
  localparam int SH  = 30 - FRAC_BITS;
  localparam int NB  = sang_pkg::NORM_BITS;
  localparam int NSQ = sang_pkg::SQRT_STEPS;
  localparam int NCR = sang_pkg::CORDIC_STEPS;
  localparam int NST = 10 + NSQ + 1 + NCR + 1;
  localparam logic [33:0] RND = 34'((64'(1) << SH) >> 1);

  logic adv;
  logic [NST:1] vld_r;
  logic [30:0] min_len_sq_r;

  // global advance: move when the output slot is free or being taken
  assign adv       = !vld_r[NST] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NST];

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_sq_r <= sang_pkg::MIN_LENGTH_SQ_RST;
    end else if (cfg_we) begin
      min_len_sq_r <= cfg_wdata;
    end
  end

  // valid bits travel with the items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-1:1], in_valid};
    end
  end

  // ---------------- stage 1: magnitudes, squares, per-vector max
  logic signed [W-1:0] vin [9];
  logic [W-1:0]  mg [9];
  logic [63:0]   mg64 [9];
  logic [W-1:0]  mx [3];

  assign vin[0] = in_start_x;
  assign vin[1] = in_start_y;
  assign vin[2] = in_start_z;
  assign vin[3] = in_end_x;
  assign vin[4] = in_end_y;
  assign vin[5] = in_end_z;
  assign vin[6] = in_axis_x;
  assign vin[7] = in_axis_y;
  assign vin[8] = in_axis_z;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mg[i]   = vin[i][W-1] ? (W'(~vin[i]) + W'(1)) : W'(vin[i]);
      mg64[i] = 64'(mg[i]);
    end
    for (int v = 0; v < 3; v++) begin
      mx[v] = mg[3*v];
      if (mg[3*v+1] > mx[v]) mx[v] = mg[3*v+1];
      if (mg[3*v+2] > mx[v]) mx[v] = mg[3*v+2];
    end
  end

  logic signed [W-1:0] comp1_r [9];
  logic [61:0]         sq1_r [6];
  logic [1:0]          huge1_r;
  logic [W-1:0]        max1_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) comp1_r[i] <= vin[i];
      for (int i = 0; i < 6; i++) begin
        sq1_r[i] <= {31'b0, mg64[i][30:0]} * {31'b0, mg64[i][30:0]};
      end
      huge1_r[0] <= |{mg64[0][63:31], mg64[1][63:31], mg64[2][63:31]};
      huge1_r[1] <= |{mg64[3][63:31], mg64[4][63:31], mg64[5][63:31]};
      for (int v = 0; v < 3; v++) max1_r[v] <= mx[v];
    end
  end

  // ---------------- stage 2: threshold test, leading-one position
  logic [63:0] sum_s, sum_e, thr;
  logic        short_s, short_e;

  always_comb begin
    sum_s   = 64'(sq1_r[0]) + 64'(sq1_r[1]) + 64'(sq1_r[2]);
    sum_e   = 64'(sq1_r[3]) + 64'(sq1_r[4]) + 64'(sq1_r[5]);
    thr     = 64'(min_len_sq_r) << FRAC_BITS;
    short_s = !huge1_r[0] && (sum_s < thr);
    short_e = !huge1_r[1] && (sum_e < thr);
  end

  logic signed [W-1:0] comp2_r [9];
  logic [6:0]          len2_r [3];
  logic                deg2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) comp2_r[i] <= comp1_r[i];
      for (int v = 0; v < 3; v++) len2_r[v] <= sang_pkg::bitlen64(64'(max1_r[v]));
      deg2_r <= short_s || short_e;
    end
  end

  // ---------------- stage 3: scale each vector to a 24-bit peak
  logic signed [63:0] ext64 [9];
  logic signed [63:0] sc64 [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      ext64[i] = 64'(comp2_r[i]);
      if (len2_r[i/3] > 7'(NB)) begin
        sc64[i] = ext64[i] >>> (len2_r[i/3] - 7'(NB));
      end else begin
        sc64[i] = ext64[i] <<< (7'(NB) - len2_r[i/3]);
      end
    end
  end

  sang_pkg::norm_t nrm3_r [9];
  logic            deg3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) nrm3_r[i] <= sc64[i][NB:0];
      deg3_r <= deg2_r;
    end
  end

  // ---------------- stage 4: partial products of s and e
  logic signed [49:0] prod4_r [9];
  sang_pkg::norm_t    ax4_r [3];
  logic               deg4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod4_r[0] <= nrm3_r[1] * nrm3_r[5];
      prod4_r[1] <= nrm3_r[2] * nrm3_r[4];
      prod4_r[2] <= nrm3_r[2] * nrm3_r[3];
      prod4_r[3] <= nrm3_r[0] * nrm3_r[5];
      prod4_r[4] <= nrm3_r[0] * nrm3_r[4];
      prod4_r[5] <= nrm3_r[1] * nrm3_r[3];
      prod4_r[6] <= nrm3_r[0] * nrm3_r[3];
      prod4_r[7] <= nrm3_r[1] * nrm3_r[4];
      prod4_r[8] <= nrm3_r[2] * nrm3_r[5];
      for (int v = 0; v < 3; v++) ax4_r[v] <= nrm3_r[6+v];
      deg4_r <= deg3_r;
    end
  end

  // ---------------- stage 5: cross product and dot product
  logic signed [51:0] c5_r [4];
  sang_pkg::norm_t    ax5_r [3];
  logic               deg5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c5_r[0] <= 52'(prod4_r[0]) - 52'(prod4_r[1]);
      c5_r[1] <= 52'(prod4_r[2]) - 52'(prod4_r[3]);
      c5_r[2] <= 52'(prod4_r[4]) - 52'(prod4_r[5]);
      c5_r[3] <= 52'(prod4_r[6]) + 52'(prod4_r[7]) + 52'(prod4_r[8]);
      ax5_r  <= ax4_r;
      deg5_r <= deg4_r;
    end
  end

  // ---------------- stage 6: largest magnitude of the four
  logic [51:0] cm [4];
  logic [51:0] cmx;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cm[i] = c5_r[i][51] ? 52'(-c5_r[i]) : 52'(c5_r[i]);
    end
    cmx = cm[0];
    for (int i = 1; i < 4; i++) begin
      if (cm[i] > cmx) cmx = cm[i];
    end
  end

  logic signed [51:0] c6_r [4];
  logic [51:0]        mx6_r;
  sang_pkg::norm_t    ax6_r [3];
  logic               deg6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c6_r   <= c5_r;
      mx6_r  <= cmx;
      ax6_r  <= ax5_r;
      deg6_r <= deg5_r;
    end
  end

  // ---------------- stage 7: common shift that brings all to at most 2^30
  logic [6:0]  clen;
  logic [5:0]  k0;
  logic [51:0] mshift;
  logic [4:0]  kk;

  always_comb begin
    clen   = sang_pkg::bitlen64(64'(mx6_r));
    k0     = '0;
    mshift = mx6_r;
    kk     = '0;
    if (clen > 7'(sang_pkg::CROSS_MAX_LOG)) begin
      k0     = 6'(clen - 7'(sang_pkg::CROSS_MAX_LOG + 1));
      mshift = mx6_r >> k0;
      kk     = 5'(k0) + 5'(mshift > (52'(1) << sang_pkg::CROSS_MAX_LOG));
    end
  end

  logic signed [51:0] c7_r [4];
  logic [4:0]         k7_r;
  sang_pkg::norm_t    ax7_r [3];
  logic               deg7_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c7_r   <= c6_r;
      k7_r   <= kk;
      ax7_r  <= ax6_r;
      deg7_r <= deg6_r;
    end
  end

  // ---------------- stage 8: apply the common shift
  logic signed [51:0] csh [4];

  always_comb begin
    for (int i = 0; i < 4; i++) csh[i] = c7_r[i] >>> k7_r;
  end

  logic signed [31:0] cp8_r [4];
  sang_pkg::norm_t    ax8_r [3];
  logic               deg8_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) cp8_r[i] <= csh[i][31:0];
      ax8_r  <= ax7_r;
      deg8_r <= deg7_r;
    end
  end

  // ---------------- stage 9: squares of the cross product, axis products
  logic [30:0] cpm [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cpm[i] = cp8_r[i][31] ? 31'(-cp8_r[i]) : 31'(cp8_r[i]);
    end
  end

  logic [61:0]        sq9_r [3];
  logic signed [56:0] tp9_r [3];
  logic signed [31:0] x9_r;
  logic               deg9_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq9_r[i] <= {31'b0, cpm[i]} * {31'b0, cpm[i]};
        tp9_r[i] <= ax8_r[i] * cp8_r[i];
      end
      x9_r   <= cp8_r[3];
      deg9_r <= deg8_r;
    end
  end

  // ---------------- stage 10: sums and sign test
  logic signed [58:0] tsum;

  assign tsum = 59'(tp9_r[0]) + 59'(tp9_r[1]) + 59'(tp9_r[2]);

  // square root pipeline, one result bit per stage; index 0 is loaded here
  logic [61:0]        qn_r   [NSQ+1];
  logic [61:0]        qres_r [NSQ+1];
  logic signed [31:0] qx_r   [NSQ+1];
  logic [NSQ:0]       qdeg_r;
  logic [NSQ:0]       qtp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      qn_r[0]   <= sq9_r[0] + sq9_r[1] + sq9_r[2];
      qres_r[0] <= '0;
      qx_r[0]   <= x9_r;
      qdeg_r[0] <= deg9_r;
      qtp_r[0]  <= !tsum[58] && (tsum != '0);
    end
  end

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (2 * (NSQ - 1 - j));
    logic [61:0] trial;

    assign trial = qres_r[j] + BIT;

    // restoring square root step
    always_ff @(posedge clk) begin
      if (adv) begin
        if (qn_r[j] >= trial) begin
          qn_r[j+1]   <= qn_r[j] - trial;
          qres_r[j+1] <= (qres_r[j] >> 1) + BIT;
        end else begin
          qn_r[j+1]   <= qn_r[j];
          qres_r[j+1] <= qres_r[j] >> 1;
        end
        qx_r[j+1]   <= qx_r[j];
        qdeg_r[j+1] <= qdeg_r[j];
        qtp_r[j+1]  <= qtp_r[j];
      end
    end
  end

  // ---------------- pre-rotation into the right half plane
  logic signed [34:0] kx_r [NCR+1];
  logic signed [34:0] ky_r [NCR+1];
  logic signed [33:0] kz_r [NCR+1];
  logic [NCR:0]       kdeg_r;
  logic [NCR:0]       ktp_r;

  logic signed [34:0] px, py;

  assign px = 35'(qx_r[NSQ]);
  assign py = {4'b0, qres_r[NSQ][30:0]};

  always_ff @(posedge clk) begin
    if (adv) begin
      if (px[34]) begin
        kx_r[0] <= py;
        ky_r[0] <= -px;
        kz_r[0] <= sang_pkg::HALF_PI_Q30;
      end else begin
        kx_r[0] <= px;
        ky_r[0] <= py;
        kz_r[0] <= '0;
      end
      kdeg_r[0] <= qdeg_r[NSQ];
      ktp_r[0]  <= qtp_r[NSQ];
    end
  end

  // ---------------- vectoring cordic, one rotation per stage
  for (genvar i = 0; i < NCR; i++) begin : g_cordic
    localparam logic signed [33:0] STEP = sang_pkg::atan_q30(i);
    logic signed [34:0] dx, dy;
    logic               ypos;

    assign dx   = ky_r[i] >>> i;
    assign dy   = kx_r[i] >>> i;
    assign ypos = !ky_r[i][34] && (ky_r[i] != '0);

    always_ff @(posedge clk) begin
      if (adv) begin
        if (ypos) begin
          kx_r[i+1] <= kx_r[i] + dx;
          ky_r[i+1] <= ky_r[i] - dy;
          kz_r[i+1] <= kz_r[i] + STEP;
        end else begin
          kx_r[i+1] <= kx_r[i] - dx;
          ky_r[i+1] <= ky_r[i] + dy;
          kz_r[i+1] <= kz_r[i] - STEP;
        end
        kdeg_r[i+1] <= kdeg_r[i];
        ktp_r[i+1]  <= ktp_r[i];
      end
    end
  end

  // ---------------- clamp, round, sign and output register
  logic [33:0] zc, zr, ang;

  always_comb begin
    if (kz_r[NCR][33]) begin
      zc = '0;
    end else if (kz_r[NCR] > sang_pkg::PI_Q30) begin
      zc = 34'(sang_pkg::PI_Q30);
    end else begin
      zc = 34'(kz_r[NCR]);
    end
    zr  = (zc + RND) >> SH;
    ang = ktp_r[NCR] ? (34'(0) - zr) : zr;
  end

  logic signed [AW-1:0] angle_r;
  logic                 deg_out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      angle_r   <= kdeg_r[NCR] ? '0 : ang[AW-1:0];
      deg_out_r <= kdeg_r[NCR];
    end
  end

  assign out_angle      = angle_r;
  assign out_degenerate = deg_out_r;

endmodule

>>> tb/tb.sv
// tb: self-checking bench for signed_angle_about_axis_core
// depends on sang_pkg and the core; predicts each angle with a bit-exact cordic model
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic signed [31:0] s[3];
    logic signed [31:0] e[3];
    logic signed [31:0] a[3];
  } query_t;

  typedef struct {
    logic signed [18:0] angle;
    logic               degenerate;
  } angle_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_start_x = '0, in_start_y = '0, in_start_z = '0;
  logic signed [31:0] in_end_x = '0, in_end_y = '0, in_end_z = '0;
  logic signed [31:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [18:0] out_angle;
  logic out_degenerate;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;

  query_t     pending_q[$];
  angle_res_t expected_q[$];
  logic [30:0] min_len_sq = sang_pkg::MIN_LENGTH_SQ_RST;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_off = 1'b0;
  int  errors = 0;
  longint cycles = 0;

  signed_angle_about_axis_core u_top (.*);

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic longint mag_of(longint v);
    return v < 0 ? -v : v;
  endfunction

  // floor shift right
  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic bit below_threshold(logic signed [31:0] v[3], logic [30:0] thr);
    longint unsigned sum;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (mag_of(v[i]) >= 64'sd2147483648) return 1'b0;
      sum += longint'(mag_of(v[i])) * mag_of(v[i]);
    end
    return sum < ({33'd0, thr} << 16);
  endfunction

  // scale a nonzero vector so the largest magnitude lands in [2^23, 2^24]
  function automatic void scale_vec(inout longint v[3]);
    longint unsigned m;
    int len;
    m = 0;
    len = 0;
    for (int i = 0; i < 3; i++) if (mag_of(v[i]) > m) m = mag_of(v[i]);
    if (m == 0) return;
    while (m != 0) begin
      len++;
      m >>= 1;
    end
    for (int i = 0; i < 3; i++) begin
      if (len > sang_pkg::NORM_BITS) v[i] = shr_floor(v[i], len - sang_pkg::NORM_BITS);
      else if (len < sang_pkg::NORM_BITS) v[i] = v[i] <<< (sang_pkg::NORM_BITS - len);
    end
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic angle_res_t predict_angle(query_t q, logic [30:0] thr);
    angle_res_t r;
    longint s[3], e[3], a[3], c[4];
    longint x, y, z, t, nx, dx, dy, stp;
    longint unsigned m, sq;
    int k;
    r.angle = '0;
    r.degenerate = 1'b1;
    if (below_threshold(q.s, thr) || below_threshold(q.e, thr)) return r;
    for (int i = 0; i < 3; i++) begin
      s[i] = q.s[i];
      e[i] = q.e[i];
      a[i] = q.a[i];
    end
    scale_vec(s);
    scale_vec(e);
    scale_vec(a);
    c[0] = s[1] * e[2] - s[2] * e[1];
    c[1] = s[2] * e[0] - s[0] * e[2];
    c[2] = s[0] * e[1] - s[1] * e[0];
    c[3] = s[0] * e[0] + s[1] * e[1] + s[2] * e[2];
    m = 0;
    for (int i = 0; i < 4; i++) if (mag_of(c[i]) > m) m = mag_of(c[i]);
    k = 0;
    while ((m >> k) > (64'd1 << 30)) k++;
    for (int i = 0; i < 4; i++) c[i] = shr_floor(c[i], k);
    sq = 0;
    for (int i = 0; i < 3; i++) sq += c[i] * c[i];
    y = floor_sqrt(sq);
    x = c[3];
    t = a[0] * c[0] + a[1] * c[1] + a[2] * c[2];
    z = 0;
    if (x < 0) begin
      nx = y;
      y = -x;
      x = nx;
      z = sang_pkg::HALF_PI_Q30;
    end
    // vectoring cordic
    for (int i = 0; i < sang_pkg::CORDIC_STEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      stp = sang_pkg::atan_q30(i);
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += stp;
      end else begin
        x -= dx;
        y += dy;
        z -= stp;
      end
    end
    if (z < 0) z = 0;
    if (z > sang_pkg::PI_Q30) z = sang_pkg::PI_Q30;
    z = (z + (64'sd1 << 13)) >>> 14;
    if (t > 0) z = -z;
    r.angle = 19'(z);
    r.degenerate = 1'b0;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(200000)) - 100000;
      2: return $signed($urandom_range(2000)) - 1000;
      3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(20000000)) - 10000000;
    endcase
  endfunction

  function automatic query_t make_query(int sv_, int ev_, int ax_);
    query_t q;
    for (int i = 0; i < 3; i++) begin
      q.s[i] = sv_;
      q.e[i] = ev_;
      q.a[i] = ax_;
    end
    return q;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (in_valid) expected_q.push_back(predict_angle(pending_q.pop_front(), min_len_sq));
        if (pending_q.size() != 0 && !hold_off && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_start_x <= pending_q[0].s[0];
          in_start_y <= pending_q[0].s[1];
          in_start_z <= pending_q[0].s[2];
          in_end_x <= pending_q[0].e[0];
          in_end_y <= pending_q[0].e[1];
          in_end_z <= pending_q[0].e[2];
          in_axis_x <= pending_q[0].a[0];
          in_axis_y <= pending_q[0].a[1];
          in_axis_z <= pending_q[0].a[2];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    angle_res_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item angle=%0d", out_angle);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_angle !== exp_r.angle) begin
            $error("angle: expected %0d actual %0d", exp_r.angle, out_angle);
            errors++;
          end
          if (out_degenerate !== exp_r.degenerate) begin
            $error("degenerate: expected %0d actual %0d", exp_r.degenerate, out_degenerate);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_threshold(logic [30:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    min_len_sq = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_random(int n);
    query_t q;
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < 3; i++) begin
        q.s[i] = rand_coord();
        q.e[i] = rand_coord();
        q.a[i] = rand_coord();
      end
      case ($urandom_range(9))
        0: q.e = q.s;
        1: for (int i = 0; i < 3; i++) q.e[i] = -q.s[i];
        2: q.a = '{0, 0, 0};
        3: q.a = q.s;
        default: ;
      endcase
      pending_q.push_back(q);
    end
  endtask

  // stimulus
  initial begin
    query_t q;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // directed items at default threshold
    pending_q.push_back(make_query(0, 0, 0));
    pending_q.push_back(make_query(1, 1, 1));
    pending_q.push_back(make_query(32'h7fffffff, 32'h7fffffff, 0));
    pending_q.push_back(make_query(32'h80000000, 32'h7fffffff, 1));
    pending_q.push_back(make_query(-1, -1, -1));
    q = make_query(0, 0, 0);
    q.s = '{65536, 0, 0}; q.e = '{0, 65536, 0}; q.a = '{0, 0, 65536};
    pending_q.push_back(q);
    q.a = '{0, 0, -65536};
    pending_q.push_back(q);
    q.e = '{-65536, 0, 0};
    pending_q.push_back(q);
    q.e = '{-65536, 1, 0};
    pending_q.push_back(q);
    q.e = '{65536, 0, 0}; q.a = '{0, 65536, 0};
    pending_q.push_back(q);
    q.s = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    q.e = '{32'sh7fffffff, 32'sh80000000, 1}; q.a = '{32'sh80000000, 0, 32'sh7fffffff};
    pending_q.push_back(q);
    send_idle_pct = 11;
    recv_idle_pct = 51;
    add_random(600);
    drain();
    // zero threshold: zero vectors pass
    set_threshold(31'd0);
    pending_q.push_back(make_query(0, 0, 0));
    q = make_query(0, 0, 0);
    q.e = '{65536, 0, 0};
    pending_q.push_back(q);
    send_idle_pct = 51;
    recv_idle_pct = 11;
    add_random(300);
    // hold the sender until the pipe empties
    while (pending_q.size() > 150) @(posedge clk);
    hold_off = 1'b1;
    while (in_valid || expected_q.size() != 0) @(posedge clk);
    hold_off = 1'b0;
    drain();
    set_threshold(31'h7fffffff);
    while (in_valid) @(posedge clk);
    pending_q.push_back(make_query(32'h7fffffff, 32'h7fffffff, 3));
    hold_off = 1'b0;
    add_random(300);
    drain();
    set_threshold(31'd100000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(700);
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sang_pkg.sv
sv/signed_angle_about_axis_core.sv
tb/tb.sv
